// ===== sv/wfev_pkg.sv =====
// ----------------------------------------------------------------------------
// wfev_pkg: shared types and constants of the wall function unit
// Number formats, saturation caps, register indexes and the structs that
// travel between the front queue, the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package wfev_pkg;

	localparam int DATA_W = 32;
	localparam int KAP_W  = 18;
	localparam int E_W    = 24;
	localparam int LAM_W  = 24;
	localparam int INT_W  = 48;
	localparam int RE_W   = 46;
	localparam int DVD_W  = 68;
	localparam int DVS_W  = 32;
	localparam int L2_W   = 22;
	localparam int T_W    = 25;
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;

	localparam int MAX_ITERATIONS = 10;
	localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_KAPPA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_E   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAMINAR = 2'd2;

	localparam logic [KAP_W-1:0] KAPPA_RST   = 18'd26870;
	localparam logic [E_W-1:0]   LOG_E_RST   = 24'd642253;
	localparam logic [LAM_W-1:0] LAMINAR_RST = 24'd755630;

	localparam logic [INT_W-1:0]  INT_CAP = {INT_W{1'b1}};
	localparam logic [RE_W-1:0]   RE_CAP  = {RE_W{1'b1}};
	localparam logic [DATA_W-1:0] OUT_CAP = {DATA_W{1'b1}};
	localparam logic [MUL_W-1:0]  LN2_Q32 = 32'd2977044472;
	localparam logic signed [T_W-1:0] ONE_Q16 = 25'sd65536;
	localparam logic signed [T_W-1:0] T_BIAS  = 25'sd2097152;

	typedef struct packed {
		logic [DATA_W-1:0] speed;
		logic [DATA_W-1:0] wall_dist;
		logic [DATA_W-1:0] nu;
		logic              nu_zero;
	} item_t;

	typedef struct packed {
		logic [KAP_W-1:0] kappa;
		logic [E_W-1:0]   log_e;
		logic [LAM_W-1:0] laminar;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] operand;
	} log_req_t;

	typedef struct packed {
		logic            done;
		logic [L2_W-1:0] result;
	} log_rsp_t;

endpackage

// ===== sv/wfev_face_if.sv =====
// ----------------------------------------------------------------------------
// wfev_face_if: input channel of the wall function unit
// One transaction carries the near-wall speed, wall distance and viscosity.
// ----------------------------------------------------------------------------
interface wfev_face_if import wfev_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] near_wall_speed;
	logic [DATA_W-1:0] wall_distance;
	logic [DATA_W-1:0] laminar_viscosity;

	modport source(output valid, near_wall_speed, wall_distance, laminar_viscosity,
		input ready);
	modport sink(input valid, near_wall_speed, wall_distance, laminar_viscosity,
		output ready);
endinterface

// ===== sv/wfev_result_if.sv =====
// ----------------------------------------------------------------------------
// wfev_result_if: result channel of the wall function unit
// One transaction carries y+ and the eddy viscosity of one wall face.
// ----------------------------------------------------------------------------
interface wfev_result_if import wfev_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] y_plus;
	logic [DATA_W-1:0] eddy_viscosity;

	modport source(output valid, y_plus, eddy_viscosity, input ready);
	modport sink(input valid, y_plus, eddy_viscosity, output ready);
endinterface

// ===== sv/wfev_front.sv =====
// ----------------------------------------------------------------------------
// wfev_front: input acceptance and item queue
// Takes face transactions, flags a zero viscosity and holds up to two items
// for the sequencer so that each side can stall on its own.
// ----------------------------------------------------------------------------
module wfev_front import wfev_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	wfev_face_if.sink   face,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	item_t              item_in;

	// classify the incoming item
	always_comb begin
		item_in.speed     = face.near_wall_speed;
		item_in.wall_dist = face.wall_distance;
		item_in.nu        = face.laminar_viscosity;
		item_in.nu_zero   = (face.laminar_viscosity == '0);
	end

	assign face.ready = (count_q != QCNT_W'(QDEPTH));
	assign push       = face.valid && face.ready;
	assign q_valid    = (count_q != '0);
	assign q_item     = mem_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

	// store the payload
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= item_in;
	end

endmodule

// ===== sv/wfev_div.sv =====
// ----------------------------------------------------------------------------
// wfev_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module wfev_div import wfev_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DVD_W);

	typedef enum logic {D_IDLE, D_RUN} dstate_t;

	dstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DVS_W-1:0]   dvs_q;
	logic [DVS_W-1:0]   rem_q;
	logic               done_q;
	logic [DVS_W:0]     shifted;
	logic               ge;

	// trial subtract of one step
	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		ge      = (shifted >= {1'b0, dvs_q});
	end

	// hold state, shift the dividend into the quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			dvd_q   <= '0;
			dvs_q   <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						dvd_q   <= req.dividend;
						dvs_q   <= req.divisor;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= ge ? DVS_W'(shifted - {1'b0, dvs_q}) : shifted[DVS_W-1:0];
					dvd_q <= {dvd_q[DVD_W-2:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DVD_W - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

// ===== sv/wfev_log2.sv =====
// ----------------------------------------------------------------------------
// wfev_log2: iterative base-2 logarithm in Q.16
// Six-step binary search for the leading one, then sixteen truncated
// squarings of the Q1.30 mantissa, one fraction bit per cycle.
// ----------------------------------------------------------------------------
module wfev_log2 import wfev_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  log_req_t req,
	output log_rsp_t rsp
);

	localparam int EXP_W  = 6;
	localparam int MANT_W = 31;
	localparam int FRAC_W = 16;

	typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} lstate_t;

	lstate_t             state_q;
	logic [2:0]          step_q;
	logic [3:0]          cnt_q;
	logic [PROD_W-1:0]   x_q;
	logic [EXP_W-1:0]    k_q;
	logic [MANT_W-1:0]   mant_q;
	logic [FRAC_W-1:0]   frac_q;
	logic                done_q;
	logic [L2_W-1:0]     result_q;
	logic [EXP_W-1:0]    sh;
	logic                hz;
	logic [PROD_W-1:0]   xn;
	logic [EXP_W-1:0]    kn;
	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]     nx;
	logic [MANT_W-1:0]   mant_n;
	logic [FRAC_W-1:0]   frac_n;

	// one step of the leading-one search
	always_comb begin
		sh = '0;
		hz = 1'b0;
		unique case (step_q)
			3'd0: begin sh = 6'd32; hz = (x_q[63:32] == '0); end
			3'd1: begin sh = 6'd16; hz = (x_q[63:48] == '0); end
			3'd2: begin sh = 6'd8;  hz = (x_q[63:56] == '0); end
			3'd3: begin sh = 6'd4;  hz = (x_q[63:60] == '0); end
			3'd4: begin sh = 6'd2;  hz = (x_q[63:62] == '0); end
			3'd5: begin sh = 6'd1;  hz = (x_q[63] == 1'b0); end
			default: begin sh = '0; hz = 1'b0; end
		endcase
		xn = hz ? (x_q << sh) : x_q;
		kn = hz ? (k_q - sh) : k_q;
	end

	// one squaring step
	always_comb begin
		sq     = mant_q * mant_q;
		nx     = sq[2*MANT_W-1:MANT_W-1];
		mant_n = nx[MANT_W] ? nx[MANT_W:1] : nx[MANT_W-1:0];
		frac_n = {frac_q[FRAC_W-2:0], nx[MANT_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= L_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			x_q      <= '0;
			k_q      <= '0;
			mant_q   <= '0;
			frac_q   <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (req.start) begin
						x_q     <= req.operand;
						k_q     <= {EXP_W{1'b1}};
						step_q  <= '0;
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					x_q    <= xn;
					k_q    <= kn;
					step_q <= step_q + 1'b1;
					if (step_q == 3'd5) begin
						mant_q  <= xn[PROD_W-1:PROD_W-MANT_W];
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= L_SQR;
					end
				end
				L_SQR: begin
					mant_q <= mant_n;
					frac_q <= frac_n;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == 4'd15) begin
						result_q <= {k_q, frac_n};
						done_q   <= 1'b1;
						state_q  <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

// ===== sv/wfev_back.sv =====
// ----------------------------------------------------------------------------
// wfev_back: wall function sequencer
// Pops one item, forms kRe, runs the y+ fixed-point iteration and the eddy
// viscosity through a shared multiplier, divider and log2 unit.
// ----------------------------------------------------------------------------
module wfev_back import wfev_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          q_valid,
	input  item_t         q_item,
	output logic          q_pop,
	wfev_result_if.source result
);

	typedef enum logic [4:0] {
		S_IDLE, S_LOGE_GO, S_LOGE_WAIT, S_P_MUL, S_P_DIV, S_RE_WAIT,
		S_K_LO, S_K_HI, S_K_SUM, S_IT_CHK, S_LOG_WAIT, S_LN_MUL, S_LN_USE,
		S_IT_WAIT, S_FIN, S_R_LO, S_R_HI, S_R_SUM, S_R_WAIT,
		S_N_LO, S_N_HI, S_N_SUM, S_OUT
	} state_t;

	state_t              state_q;
	item_t               item_q;
	logic [INT_W-1:0]    kre_q;
	logic [INT_W-1:0]    yp_q;
	logic [INT_W-1:0]    op_q;
	logic [L2_W-1:0]     l2e_q;
	logic signed [T_W-1:0] t_q;
	logic [DVS_W-1:0]    ul_q;
	logic [ITER_W-1:0]   iter_q;
	logic                fin_q;
	logic [PROD_W-1:0]   acc_q;
	logic [DATA_W-1:0]   nut_q;
	logic                res_valid_q;
	logic [DATA_W-1:0]   y_res_q;
	logic [DATA_W-1:0]   nut_res_q;
	logic [PROD_W-1:0]   mul_q;
	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	div_req_t            div_req_q;
	div_rsp_t            div_rsp;
	log_req_t            log_req_q;
	log_rsp_t            log_rsp;

	logic signed [T_W-1:0] t_n;
	logic [T_W-1:0]        t_abs;
	logic [22:0]           m_ln;
	logic signed [T_W-1:0] ln_n;
	logic signed [T_W-1:0] d_n;
	logic [INT_W:0]        num;
	logic [INT_W-1:0]      quot_sat;
	logic [INT_W-1:0]      diff;
	logic [54:0]           diff100;
	logic [ITER_W-1:0]     iter_n;
	logic [PROD_W-1:0]     k_sum;
	logic [65:0]           r_sum;
	logic [79:0]           n_sum;
	logic                  out_free;

	wfev_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	wfev_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (log_req_q),
		.rsp    (log_rsp)
	);

	// select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_P_MUL:  begin mul_a = item_q.speed; mul_b = item_q.wall_dist; end
			S_K_LO:   begin mul_a = {9'b0, op_q[22:0]}; mul_b = {14'b0, cfg.kappa}; end
			S_K_HI:   begin mul_a = {9'b0, op_q[45:23]}; mul_b = {14'b0, cfg.kappa}; end
			S_LN_MUL: begin mul_a = {7'b0, t_abs}; mul_b = LN2_Q32; end
			S_R_LO:   begin mul_a = {8'b0, yp_q[23:0]}; mul_b = {14'b0, cfg.kappa}; end
			S_R_HI:   begin mul_a = {8'b0, yp_q[47:24]}; mul_b = {14'b0, cfg.kappa}; end
			S_N_LO:   begin mul_a = item_q.nu; mul_b = {8'b0, op_q[23:0]}; end
			S_N_HI:   begin mul_a = item_q.nu; mul_b = {8'b0, op_q[47:24]}; end
			default:  begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// register every product
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// logarithm, iteration and saturation arithmetic
	always_comb begin
		t_n      = $signed({3'b000, l2e_q}) + $signed({3'b000, log_rsp.result}) - T_BIAS;
		t_abs    = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
		m_ln     = mul_q[54:32];
		ln_n     = t_q[T_W-1] ? -$signed({2'b00, m_ln}) : $signed({2'b00, m_ln});
		d_n      = ln_n + ONE_Q16;
		num      = {1'b0, kre_q} + {1'b0, yp_q};
		quot_sat = (div_rsp.quotient > {{(DVD_W-INT_W){1'b0}}, INT_CAP}) ?
			INT_CAP : div_rsp.quotient[INT_W-1:0];
		diff     = (quot_sat > yp_q) ? (quot_sat - yp_q) : (yp_q - quot_sat);
		diff100  = ({7'b0, diff} << 6) + ({7'b0, diff} << 5) + ({7'b0, diff} << 2);
		iter_n   = iter_q + 1'b1;
		k_sum    = acc_q + {mul_q[40:0], 23'b0};
		r_sum    = {2'b00, acc_q} + {mul_q[41:0], 24'b0};
		n_sum    = {16'b0, acc_q} + {mul_q[55:0], 24'b0};
		out_free = !res_valid_q || result.ready;
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;

	// hold state, sequence the work, register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			div_req_q   <= '0;
			log_req_q   <= '0;
			iter_q      <= '0;
			fin_q       <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			log_req_q.start <= 1'b0;
			if (res_valid_q && result.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						state_q <= S_LOGE_GO;
					end
				end
				S_LOGE_GO: begin
					if (cfg.log_e == '0) begin
						state_q <= S_P_MUL;
					end else begin
						log_req_q.start   <= 1'b1;
						log_req_q.operand <= {{(PROD_W-E_W){1'b0}}, cfg.log_e};
						state_q           <= S_LOGE_WAIT;
					end
				end
				S_LOGE_WAIT: begin
					if (log_rsp.done) begin
						l2e_q   <= log_rsp.result;
						state_q <= S_P_MUL;
					end
				end
				S_P_MUL: state_q <= S_P_DIV;
				S_P_DIV: begin
					yp_q   <= {{(INT_W-LAM_W){1'b0}}, cfg.laminar};
					iter_q <= '0;
					if (item_q.nu_zero) begin
						kre_q   <= INT_CAP;
						state_q <= S_IT_CHK;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= {mul_q, 4'b0};
						div_req_q.divisor  <= item_q.nu;
						state_q            <= S_RE_WAIT;
					end
				end
				S_RE_WAIT: begin
					if (div_rsp.done) begin
						op_q    <= (div_rsp.quotient > {{(DVD_W-RE_W){1'b0}}, RE_CAP}) ?
							{2'b00, RE_CAP} : {2'b00, div_rsp.quotient[RE_W-1:0]};
						state_q <= S_K_LO;
					end
				end
				S_K_LO: state_q <= S_K_HI;
				S_K_HI: begin
					acc_q   <= mul_q;
					state_q <= S_K_SUM;
				end
				S_K_SUM: begin
					kre_q   <= k_sum[PROD_W-1:16];
					state_q <= S_IT_CHK;
				end
				S_IT_CHK: begin
					if (yp_q == '0 || cfg.log_e == '0) begin
						yp_q    <= '0;
						state_q <= S_FIN;
					end else begin
						log_req_q.start   <= 1'b1;
						log_req_q.operand <= {{(PROD_W-INT_W){1'b0}}, yp_q};
						fin_q             <= 1'b0;
						state_q           <= S_LOG_WAIT;
					end
				end
				S_LOG_WAIT: begin
					if (log_rsp.done) begin
						t_q     <= t_n;
						state_q <= S_LN_MUL;
					end
				end
				S_LN_MUL: state_q <= S_LN_USE;
				S_LN_USE: begin
					if (!fin_q) begin
						if (d_n[T_W-1] || d_n == '0) begin
							yp_q    <= '0;
							state_q <= S_FIN;
						end else begin
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= {3'b000, num, 16'b0};
							div_req_q.divisor  <= {7'b0, d_n};
							state_q            <= S_IT_WAIT;
						end
					end else begin
						if (!ln_n[T_W-1] && ln_n != '0) begin
							ul_q    <= {7'b0, ln_n};
							state_q <= S_R_LO;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_IT_WAIT: begin
					if (div_rsp.done) begin
						yp_q   <= quot_sat;
						iter_q <= iter_n;
						if (diff100 > {31'b0, cfg.laminar} &&
							iter_n < ITER_W'(MAX_ITERATIONS)) begin
							state_q <= S_IT_CHK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					nut_q <= '0;
					if (yp_q > {{(INT_W-LAM_W){1'b0}}, cfg.laminar} && cfg.log_e != '0) begin
						log_req_q.start   <= 1'b1;
						log_req_q.operand <= {{(PROD_W-INT_W){1'b0}}, yp_q};
						fin_q             <= 1'b1;
						state_q           <= S_LOG_WAIT;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_R_LO: state_q <= S_R_HI;
				S_R_HI: begin
					acc_q   <= mul_q;
					state_q <= S_R_SUM;
				end
				S_R_SUM: begin
					div_req_q.start    <= 1'b1;
					div_req_q.dividend <= {2'b00, r_sum};
					div_req_q.divisor  <= ul_q;
					state_q            <= S_R_WAIT;
				end
				S_R_WAIT: begin
					if (div_rsp.done) begin
						if (quot_sat > INT_W'(65536) && !item_q.nu_zero) begin
							op_q    <= quot_sat - INT_W'(65536);
							state_q <= S_N_LO;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_N_LO: state_q <= S_N_HI;
				S_N_HI: begin
					acc_q   <= mul_q;
					state_q <= S_N_SUM;
				end
				S_N_SUM: begin
					nut_q   <= (n_sum[79:48] != '0) ? OUT_CAP : n_sum[47:16];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						y_res_q     <= (yp_q[INT_W-1:DATA_W] != '0) ? OUT_CAP : yp_q[DATA_W-1:0];
						nut_res_q   <= nut_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid          = res_valid_q;
	assign result.y_plus         = y_res_q;
	assign result.eddy_viscosity = nut_res_q;

endmodule

// ===== sv/wall_function_eddy_viscosity_unit.sv =====
// ----------------------------------------------------------------------------
// wall_function_eddy_viscosity_unit: log-law y+ and eddy viscosity per wall face
// Items are processed one at a time; a two-entry queue takes new items meanwhile.
// Reset: arst_n clears control state and loads the constants' default values.
// ----------------------------------------------------------------------------
module wall_function_eddy_viscosity_unit import wfev_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	wfev_face_if.sink             face,
	wfev_result_if.source         result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// write the constant registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kappa   <= KAPPA_RST;
			cfg_q.log_e   <= LOG_E_RST;
			cfg_q.laminar <= LAMINAR_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KAPPA:   cfg_q.kappa   <= cfg_wr_data[KAP_W-1:0];
				REG_LOG_E:   cfg_q.log_e   <= cfg_wr_data[E_W-1:0];
				REG_LAMINAR: cfg_q.laminar <= cfg_wr_data[LAM_W-1:0];
				default: ;
			endcase
		end
	end

	wfev_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.face    (face),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	wfev_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("sequencer popped an empty queue");
	a_pop_single: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !q_pop) else $error("sequencer popped two items back to back");
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		face.valid && face.ready |=> q_valid) else $error("accepted item not queued");
`endif

endmodule

// ===== verif/wfev_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wfev_checker: wall function result checker
// Watches the face, result and register ports, predicts y+ and the eddy
// viscosity of every accepted face and compares each result in order.
// ----------------------------------------------------------------------------
module wfev_checker import wfev_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	wfev_face_if                  face,
	wfev_result_if                result,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	output int                    fail_count,
	output int                    pending
);

	typedef struct {
		bit [DATA_W-1:0] y_plus;
		bit [DATA_W-1:0] eddy_viscosity;
	} face_result_t;

	localparam bit [63:0] CAP48   = (64'd1 << 48) - 1;
	localparam bit [63:0] CAP46   = (64'd1 << 46) - 1;
	localparam bit [63:0] CAP32   = 64'hFFFF_FFFF;
	localparam bit [63:0] LN2_Q   = 64'd2977044472;
	localparam longint    Q16_ONE = 65536;

	bit [KAP_W-1:0] kappa;
	bit [E_W-1:0]   log_e;
	bit [LAM_W-1:0] laminar;
	face_result_t   expected_results[$];

	// log2 of a nonzero value, unsigned Q.16, by repeated squaring
	function automatic bit [63:0] log2_fixed(bit [63:0] n);
		int        k;
		bit [63:0] x;
		bit [63:0] frac;
		k = 63;
		frac = 0;
		while (k > 0 && n[k] == 1'b0)
			k--;
		x = (k >= 30) ? (n >> (k - 30)) : (n << (30 - k));
		for (int i = 0; i < 16; i++) begin
			x = (x * x) >> 30;
			frac = frac << 1;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(k) << 16) | frac;
	endfunction

	// natural log of a product of two Q.16 values, signed Q.16
	function automatic longint ln_product(bit [63:0] a, bit [63:0] b);
		longint    t;
		bit [63:0] m;
		t = longint'(log2_fixed(a)) + longint'(log2_fixed(b)) - (longint'(32) << 16);
		m = (t < 0) ? 64'(-t) : 64'(t);
		m = (m * LN2_Q) >> 32;
		return (t < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic face_result_t wall_law(bit [31:0] speed, bit [31:0] wall_dist,
		bit [31:0] nu);
		face_result_t res;
		bit [63:0]    kap, e, lam, kre, yp, nut, p, q, r, re, last, num, ud, diff;
		bit [63:0]    ul, ratio, f;
		bit [127:0]   wide;
		longint       d, l;
		kap = kappa;
		e = log_e;
		lam = laminar;
		nut = 0;
		// Reynolds number times kappa, saturated for zero viscosity
		if (nu == 0) begin
			kre = CAP48;
		end else begin
			p = 64'(speed) * 64'(wall_dist);
			q = p / nu;
			r = p % nu;
			if (q > (CAP46 >> 4))
				re = CAP46;
			else
				re = (q << 4) + ((r << 4) / nu);
			if (re > CAP46)
				re = CAP46;
			kre = (re * kap) >> 16;
		end
		// fixed-point y+ iteration from the laminar limit
		yp = lam;
		for (int it = 0; it < MAX_ITERATIONS; it++) begin
			last = yp;
			if (yp == 0 || e == 0) begin
				yp = 0;
				break;
			end
			d = Q16_ONE + ln_product(e, yp);
			if (d <= 0) begin
				yp = 0;
				break;
			end
			ud = 64'(d);
			num = kre + yp;
			q = num / ud;
			r = num % ud;
			if ((q >> 32) != 0)
				yp = CAP48;
			else
				yp = (q << 16) + ((r << 16) / ud);
			if (yp > CAP48)
				yp = CAP48;
			diff = (yp > last) ? (yp - last) : (last - yp);
			if (!(diff * 100 > lam))
				break;
		end
		// eddy viscosity above the laminar limit only
		if (yp > lam && e != 0) begin
			l = ln_product(e, yp);
			if (l > 0) begin
				ul = 64'(l);
				q = yp / ul;
				r = yp % ul;
				if (kap != 0 && q > CAP48 / kap)
					ratio = CAP48;
				else
					ratio = q * kap + (r * kap) / ul;
				if (ratio > CAP48)
					ratio = CAP48;
				if (ratio > 64'(Q16_ONE) && nu != 0) begin
					f = ratio - 64'(Q16_ONE);
					wide = 128'(nu) * 128'(f);
					if (wide[127:64] != 0) begin
						nut = CAP32;
					end else begin
						nut = wide[63:0] >> 16;
						if (nut > CAP32)
							nut = CAP32;
					end
				end
			end
		end
		res.y_plus = (yp > CAP32) ? 32'hFFFF_FFFF : yp[31:0];
		res.eddy_viscosity = nut[31:0];
		return res;
	endfunction

	// track registers, predict on each face transaction, compare each result
	always @(posedge clk or negedge arst_n) begin
		face_result_t exp_res;
		if (!arst_n) begin
			kappa <= KAPPA_RST;
			log_e <= LOG_E_RST;
			laminar <= LAMINAR_RST;
			fail_count <= 0;
			pending <= 0;
			expected_results.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_KAPPA: begin
						kappa <= cfg_wr_data[KAP_W-1:0];
					end
					REG_LOG_E: begin
						log_e <= cfg_wr_data[E_W-1:0];
					end
					REG_LAMINAR: begin
						laminar <= cfg_wr_data[LAM_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (face.valid && face.ready)
				expected_results.push_back(wall_law(face.near_wall_speed,
					face.wall_distance, face.laminar_viscosity));
			if (result.valid && result.ready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result y_plus=%h eddy=%h",
							result.y_plus, result.eddy_viscosity);
					fail_count <= fail_count + 1;
				end else begin
					exp_res = expected_results.pop_front();
					if (result.y_plus !== exp_res.y_plus ||
						result.eddy_viscosity !== exp_res.eddy_viscosity) begin
						if (fail_count < 10)
							$display("ERROR: y_plus exp %h got %h, eddy exp %h got %h",
								exp_res.y_plus, result.y_plus,
								exp_res.eddy_viscosity, result.eddy_viscosity);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_results.size();
		end
	end

endmodule

// ===== verif/wall_function_eddy_viscosity_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wall_function_eddy_viscosity_unit_tb: wall function unit testbench
// Drives directed and random wall faces under several register settings,
// with random idling on both sides and one long result stall; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module wall_function_eddy_viscosity_unit_tb;
	import wfev_pkg::*;

	localparam int IDLE_LIMIT = 40000;
	localparam int PHASES     = 7;
	localparam int PER_PHASE  = 86;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;
	int                    fail_count;
	int                    pending;
	int                    idle_cycles;
	int                    faces_sent;
	bit                    steady;

	wfev_face_if   face();
	wfev_result_if result();

	wall_function_eddy_viscosity_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.face(face),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	wfev_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.face(face),
		.result(result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random back-pressure plus one long hold-off
	initial begin
		int  hold;
		bit  held_once;
		hold = 0;
		held_once = 0;
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held_once && faces_sent >= 120) begin
				held_once = 1;
				hold = 3000;
			end
			if (hold > 0) begin
				hold--;
				result.ready <= 1'b0;
			end else begin
				result.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 11);
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((face.valid && face.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// offer one face and hold it until the transaction completes
	task automatic send_face(logic [31:0] speed, logic [31:0] dist_in, logic [31:0] nu);
		face.valid <= 1'b1;
		face.near_wall_speed <= speed;
		face.wall_distance <= dist_in;
		face.laminar_viscosity <= nu;
		@(negedge clk);
		while (!face.ready)
			@(negedge clk);
		@(posedge clk);
		faces_sent++;
		if (!steady) begin
			while ($urandom_range(0, 99) < 11) begin
				face.valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] any_field();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom >> $urandom_range(0, 31);
			2: return $urandom_range(0, 15);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 3);
		endcase
	endfunction

	initial begin
		logic [23:0] kap_set[PHASES] = '{24'd26870, 24'd0, 24'h3FFFF, 24'd40000,
			24'd26870, 24'd13000, 24'd26870};
		logic [23:0] e_set[PHASES] = '{24'd642253, 24'd0, 24'hFFFFFF, 24'd65536,
			24'd642253, 24'd300000, 24'd642253};
		logic [23:0] lam_set[PHASES] = '{24'd755630, 24'd755630, 24'hFFFFFF, 24'd0,
			24'd65536, 24'd2000000, 24'd755630};
		face.valid = 1'b0;
		face.near_wall_speed = '0;
		face.wall_distance = '0;
		face.laminar_viscosity = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_KAPPA;
		cfg_wr_data = '0;
		idle_cycles = 0;
		faces_sent = 0;
		steady = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed faces at reset settings: extremes, zero viscosity, typical flow
		send_face(32'd0, 32'd0, 32'd0);
		send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
		send_face(32'd1, 32'd1, 32'hFFFF_FFFF);
		send_face(32'd1 << 20, 32'd4294967, 32'd16492674);
		send_face(32'd10 << 20, 32'd42949673, 32'd16492674);
		send_face(32'd1 << 16, 32'd429497, 32'd16492674);
		send_face(32'd0, 32'd5000, 32'd100);
		send_face(32'h8000_0000, 32'h0000_0001, 32'h0000_0002);
		send_face(32'hAAAA_AAAA, 32'h5555_5555, 32'h3333_3333);
		send_face(32'h5555_5555, 32'hAAAA_AAAA, 32'hCCCC_CCCC);

		for (int ph = 0; ph < PHASES; ph++) begin
			// drop the offer and reconfigure only once the unit has drained
			face.valid <= 1'b0;
			@(posedge clk);
			wait (pending == 0);
			@(posedge clk);
			write_reg(REG_KAPPA, kap_set[ph]);
			write_reg(REG_LOG_E, e_set[ph]);
			write_reg(REG_LAMINAR, lam_set[ph]);
			if (ph == 3) begin
				// zero limit, small E and large kappa: log of zero and negative terms
				send_face(32'd1 << 20, 32'd1 << 22, 32'd1 << 24);
				send_face(32'd0, 32'd0, 32'd1);
			end
			for (int i = 0; i < PER_PHASE; i++) begin
				steady = (ph == 4 && i < 60);
				if ($urandom_range(0, 3) != 0)
					send_face($urandom_range(32'd1 << 14, 32'd1 << 26),
						$urandom_range(32'd1 << 14, 32'd1 << 28),
						$urandom_range(32'd1 << 18, 32'd1 << 30));
				else
					send_face(any_field(), any_field(), any_field());
			end
			steady = 0;
		end
		face.valid <= 1'b0;
		@(posedge clk);

		wait (pending == 0);
		repeat (1300) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
